[hw/rtl/pid_controller_clamped_integral_core_macros.svh]
// Assertion macros for the PID core.
// Needs nothing else; the asserting files take it in by `include.
`ifndef PID_CONTROLLER_CLAMPED_INTEGRAL_CORE_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_INTEGRAL_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PIDC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the house clock and reset names.
`define PIDC_ASSERT(label, prop, msg) \
  `PIDC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/pidc_pkg.sv]
// Shared types and constants of the PID core.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  localparam int unsigned ErrW  = 16;
  localparam int unsigned GainW = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PwmW  = 8;
  localparam int unsigned RawW  = 29;
  localparam int unsigned DoneW = 2;

  // Magnitude of a 16-bit operand times a 15-bit gain.
  localparam int unsigned ProdW = 31;
  // Widths of the truncated quotients (bounded by the operand ranges).
  localparam int unsigned PQuoW = 24;
  localparam int unsigned IQuoW = 21;
  localparam int unsigned DQuoW = 28;

  localparam logic [7:0] PwmCenter = 8'd127;
  localparam logic [7:0] PwmMax    = 8'd254;

  // Reciprocals for exact unsigned division of 32-bit values.
  localparam logic [31:0] RecipDiv100  = 32'h51EB_851F;
  localparam int unsigned ShiftDiv100  = 37;
  localparam logic [31:0] RecipDiv1000 = 32'h1062_4DD3;
  localparam int unsigned ShiftDiv1000 = 38;
  localparam logic [31:0] RecipDiv10   = 32'hCCCC_CCCD;
  localparam int unsigned ShiftDiv10   = 35;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKp        = 3'd0,
    CfgKi        = 3'd1,
    CfgKd        = 3'd2,
    CfgIntLimit  = 3'd3,
    CfgThreshold = 3'd4
  } cfg_idx_e;

  typedef enum logic [DoneW-1:0] {
    DoneOutside = 2'd0,
    DoneSettled = 2'd1,
    DoneMoving  = 2'd2
  } done_e;

  // Products stage: magnitudes and signs of the three terms.
  typedef struct packed {
    logic             p_neg;
    logic             i_neg;
    logic             d_neg;
    logic [ProdW-1:0] p_mag;
    logic [ProdW-1:0] i_mag;
    logic [ProdW-1:0] d_mag;
    done_e            done;
  } prod_t;

  // Quotient stage: truncated magnitudes after constant division.
  typedef struct packed {
    logic             p_neg;
    logic             i_neg;
    logic             d_neg;
    logic [PQuoW-1:0] p_quo;
    logic [IQuoW-1:0] i_quo;
    logic [DQuoW-1:0] d_quo;
    done_e            done;
  } quo_t;

endpackage

`default_nettype wire

[hw/rtl/pidc_err_if.sv]
// Input channel of the PID core: one signed error sample per transaction.
// Depends on pidc_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface pidc_err_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidc_pkg::ErrW-1:0]    error;

  modport source (output valid, output error, input ready);
  modport sink   (input valid, input error, output ready);
endinterface

`default_nettype wire

[hw/rtl/pidc_res_if.sv]
// Result channel of the PID core: pwm, raw drive and done status.
// Depends on pidc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pidc_res_if;
  logic                               valid;
  logic                               ready;
  logic        [pidc_pkg::PwmW-1:0]   pwm;
  logic signed [pidc_pkg::RawW-1:0]   raw_drive;
  logic        [pidc_pkg::DoneW-1:0]  done_status;

  modport source (output valid, output pwm, output raw_drive, output done_status,
                  input ready);
  modport sink   (input valid, input pwm, input raw_drive, input done_status,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/pid_controller_clamped_integral_core.sv]
// Top level of the PID core with clamped integral.
// Depends on pidc_pkg, pidc_err_if, pidc_res_if and the assertion macro header.
//
//   channel  direction  transaction                       handshake
//   err_i    in         error (16 b signed)               valid/ready
//   res_o    out        pwm, raw_drive, done_status       valid/ready
//   cfg      in         cfg_idx_i, cfg_wdata_i            cfg_we_i, no wait
//
// One transaction per cycle sustained while res_o takes results; each result passes
// through the chain input register -> gain products -> reciprocal division ->
// sum and saturation, one register each.
// Integral and previous-error state update as the sample leaves the input
// register, so consecutive samples see each other without a gap.
// Reset clears the gains, limits, state and all valid bits.
// A stall at res_o backs up stage by stage; err_i drops ready only once
// every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

`include "pid_controller_clamped_integral_core_macros.svh"

module pid_controller_clamped_integral_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pidc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [pidc_pkg::GainW-1:0]        cfg_wdata_i,
  pidc_err_if.sink                               err_i,
  pidc_res_if.source                             res_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [pidc_pkg::GainW-1:0] kp_q, ki_q, kd_q, lim_q, thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      ki_q  <= '0;
      kd_q  <= '0;
      lim_q <= '0;
      thr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidc_pkg::CfgKp:        kp_q  <= cfg_wdata_i;
        pidc_pkg::CfgKi:        ki_q  <= cfg_wdata_i;
        pidc_pkg::CfgKd:        kd_q  <= cfg_wdata_i;
        pidc_pkg::CfgIntLimit:  lim_q <= cfg_wdata_i;
        pidc_pkg::CfgThreshold: thr_q <= cfg_wdata_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: each stage advances when the one after it is free or moving
  // ---------------------------------------------------------------------
  logic in_v_q, prod_v_q, quo_v_q, out_v_q;
  logic in_v_d, prod_v_d, quo_v_d, out_v_d;
  logic rdy_out, rdy_quo, rdy_prod, rdy_in;
  logic in_fire, adv_prod, adv_quo, adv_out;

  assign rdy_out  = !out_v_q  || res_o.ready;
  assign rdy_quo  = !quo_v_q  || rdy_out;
  assign rdy_prod = !prod_v_q || rdy_quo;
  assign rdy_in   = !in_v_q   || rdy_prod;

  assign err_i.ready = rdy_in;
  assign in_fire  = err_i.valid && rdy_in;
  assign adv_prod = in_v_q   && rdy_prod;
  assign adv_quo  = prod_v_q && rdy_quo;
  assign adv_out  = quo_v_q  && rdy_out;

  assign in_v_d   = in_fire  || (in_v_q   && !rdy_prod);
  assign prod_v_d = adv_prod || (prod_v_q && !rdy_quo);
  assign quo_v_d  = adv_quo  || (quo_v_q  && !rdy_out);
  assign out_v_d  = adv_out  || (out_v_q  && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      quo_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      in_v_q   <= in_v_d;
      prod_v_q <= prod_v_d;
      quo_v_q  <= quo_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic signed [pidc_pkg::ErrW-1:0] err_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q <= err_i.error;
    end
  end

  // ---------------------------------------------------------------------
  // Products stage: state update, band check and the three gain products
  // ---------------------------------------------------------------------
  logic signed [pidc_pkg::ErrW-1:0] prev_q, prev_d;
  logic signed [pidc_pkg::ErrW-1:0] acc_q, acc_d;
  logic signed [pidc_pkg::ErrW:0]   err_x, diff_x, sum_x, lim_x, thr_x;
  logic signed [pidc_pkg::ErrW:0]   err_abs_x, acc_abs_x, diff_abs_x;
  logic [pidc_pkg::ErrW-1:0]        err_mag, acc_mag, diff_mag;
  logic                             in_band;
  pidc_pkg::prod_t                  prod_d, prod_q;

  always_comb begin
    err_x  = {err_q[pidc_pkg::ErrW-1], err_q};
    diff_x = {prev_q[pidc_pkg::ErrW-1], prev_q} - err_x;
    sum_x  = {acc_q[pidc_pkg::ErrW-1], acc_q} + err_x;
    lim_x  = {2'b00, lim_q};
    thr_x  = {2'b00, thr_q};

    // clamp the running sum to the symmetric limit
    priority if (sum_x > lim_x) begin
      acc_d = lim_x[pidc_pkg::ErrW-1:0];
    end else if (sum_x < -lim_x) begin
      acc_d = 16'(-lim_x);
    end else begin
      acc_d = sum_x[pidc_pkg::ErrW-1:0];
    end
    prev_d = err_q;

    // band edges count as inside
    in_band = (err_x <= thr_x) && (err_x >= -thr_x);

    err_abs_x  = err_x[pidc_pkg::ErrW] ? -err_x : err_x;
    acc_abs_x  = acc_q[pidc_pkg::ErrW-1] ? -{acc_q[pidc_pkg::ErrW-1], acc_q}
                                         :  {acc_q[pidc_pkg::ErrW-1], acc_q};
    diff_abs_x = diff_x[pidc_pkg::ErrW] ? -diff_x : diff_x;
    err_mag    = err_abs_x[pidc_pkg::ErrW-1:0];
    acc_mag    = acc_abs_x[pidc_pkg::ErrW-1:0];
    diff_mag   = diff_abs_x[pidc_pkg::ErrW-1:0];

    prod_d.p_neg = err_x[pidc_pkg::ErrW];
    prod_d.i_neg = acc_q[pidc_pkg::ErrW-1];
    prod_d.d_neg = diff_x[pidc_pkg::ErrW];
    prod_d.p_mag = pidc_pkg::ProdW'(err_mag) * pidc_pkg::ProdW'(kp_q);
    prod_d.i_mag = pidc_pkg::ProdW'(acc_mag) * pidc_pkg::ProdW'(ki_q);
    prod_d.d_mag = pidc_pkg::ProdW'(diff_mag) * pidc_pkg::ProdW'(kd_q);

    priority if (!in_band) begin
      prod_d.done = pidc_pkg::DoneOutside;
    end else if (diff_x == '0) begin
      prod_d.done = pidc_pkg::DoneSettled;
    end else begin
      prod_d.done = pidc_pkg::DoneMoving;
    end
  end

  // advance the controller state as the sample leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      acc_q  <= '0;
    end else if (adv_prod) begin
      prev_q <= prev_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_prod) begin
      prod_q <= prod_d;
    end
  end

  // ---------------------------------------------------------------------
  // Quotient stage: truncating division by constants via reciprocals
  // ---------------------------------------------------------------------
  logic [63:0]     p_recip, i_recip, d_recip;
  pidc_pkg::quo_t  quo_d, quo_q;

  always_comb begin
    p_recip = {1'b0, prod_q.p_mag} * pidc_pkg::RecipDiv100;
    i_recip = {1'b0, prod_q.i_mag} * pidc_pkg::RecipDiv1000;
    d_recip = {1'b0, prod_q.d_mag} * pidc_pkg::RecipDiv10;

    quo_d.p_neg = prod_q.p_neg;
    quo_d.i_neg = prod_q.i_neg;
    quo_d.d_neg = prod_q.d_neg;
    quo_d.p_quo = p_recip[pidc_pkg::ShiftDiv100  +: pidc_pkg::PQuoW];
    quo_d.i_quo = i_recip[pidc_pkg::ShiftDiv1000 +: pidc_pkg::IQuoW];
    quo_d.d_quo = d_recip[pidc_pkg::ShiftDiv10   +: pidc_pkg::DQuoW];
    quo_d.done  = prod_q.done;
  end

  always_ff @(posedge clk_i) begin
    if (adv_quo) begin
      quo_q <= quo_d;
    end
  end

  // ---------------------------------------------------------------------
  // Sum stage: restore signs, P + I - D, saturate the drive
  // ---------------------------------------------------------------------
  logic signed [pidc_pkg::RawW-1:0] p_term, i_term, d_term, raw_d;
  logic signed [pidc_pkg::RawW:0]   drive;
  logic [pidc_pkg::PwmW-1:0]        pwm_d;

  logic [pidc_pkg::PwmW-1:0]        pwm_q;
  logic signed [pidc_pkg::RawW-1:0] raw_q;
  pidc_pkg::done_e                  done_q;

  always_comb begin
    p_term = quo_q.p_neg ? -$signed({5'b0, quo_q.p_quo}) : $signed({5'b0, quo_q.p_quo});
    i_term = quo_q.i_neg ? -$signed({8'b0, quo_q.i_quo}) : $signed({8'b0, quo_q.i_quo});
    d_term = quo_q.d_neg ? -$signed({1'b0, quo_q.d_quo}) : $signed({1'b0, quo_q.d_quo});
    raw_d  = p_term + i_term - d_term;

    drive = {raw_d[pidc_pkg::RawW-1], raw_d} + $signed({22'b0, pidc_pkg::PwmCenter});
    priority if (drive > $signed({22'b0, pidc_pkg::PwmMax})) begin
      pwm_d = pidc_pkg::PwmMax;
    end else if (drive[pidc_pkg::RawW]) begin
      pwm_d = '0;
    end else begin
      pwm_d = drive[pidc_pkg::PwmW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      pwm_q  <= pwm_d;
      raw_q  <= raw_d;
      done_q <= quo_q.done;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.pwm         = pwm_q;
  assign res_o.raw_drive   = raw_q;
  assign res_o.done_status = done_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic                          raw_near_zero, pwm_lin_ok, all_full;
  logic [pidc_pkg::PwmW-1:0]     pwm_lin;
  logic [2*pidc_pkg::ErrW-1:0]   state_vec;

  assign raw_near_zero = (res_o.raw_drive > -29'sd128) && (res_o.raw_drive < 29'sd128);
  assign pwm_lin       = res_o.raw_drive[pidc_pkg::PwmW-1:0] + pidc_pkg::PwmCenter;
  assign pwm_lin_ok    = !raw_near_zero || (res_o.pwm == pwm_lin);
  assign all_full      = in_v_q && prod_v_q && quo_v_q && out_v_q;
  assign state_vec     = {acc_q, prev_q};

  `PIDC_ASSERT(a_pwm_bound, res_o.valid |-> (res_o.pwm <= pidc_pkg::PwmMax), "pwm above ceiling")
  `PIDC_ASSERT(a_pwm_linear, res_o.valid |-> pwm_lin_ok, "pwm disagrees with raw drive")
  `PIDC_ASSERT(a_full_when_blocked, !err_i.ready |-> all_full, "input blocked with a free stage")
  `PIDC_ASSERT(a_state_hold, !$past(adv_prod) |-> $stable(state_vec), "idle state moved")

endmodule

`default_nettype wire
